// File: rtl/vgd_pkg.sv
// Package for the voxel grid downsampler: shared widths, types and constants.
// No dependencies.
`default_nettype none
package vgd_pkg;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned SIZE_W  = 31;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

   typedef enum logic [0:0] {
      MODE_ADD   = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] centroid_x;
      logic signed [DATA_W-1:0] centroid_y;
      logic signed [DATA_W-1:0] centroid_z;
      logic                     last_voxel;
      logic                     table_empty;
      logic                     overflowed;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/vgd_req_if.sv
// Valid/ready channel interface carrying a downsampler request.
// Depends on vgd_pkg.
`default_nettype none
interface vgd_req_if;
   logic             valid;
   logic             ready;
   vgd_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/vgd_rsp_if.sv
// Valid/ready channel interface carrying a downsampler result.
// Depends on vgd_pkg.
`default_nettype none
interface vgd_rsp_if;
   logic             valid;
   logic             ready;
   vgd_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/vgd_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on vgd_pkg only through the caller's widths; standalone otherwise.
`default_nettype none
module vgd_div #(
   parameter int unsigned NUM_W = 64,
   parameter int unsigned DEN_W = 33
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [DEN_W-1:0] den,
   output logic                         done,
   output logic signed [NUM_W-1:0]      quot,
   output logic signed [NUM_W-1:0]      rem
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [NUM_W:0]   r_ff, r_in;
   logic [NUM_W-1:0] d_ff, d_in;
   logic             qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff;
   logic [NUM_W:0]   trial;
   logic [NUM_W-1:0] anum, aden;

   always_comb begin
      anum = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      aden = den[DEN_W-1] ? NUM_W'(-$signed({{(NUM_W-DEN_W){den[DEN_W-1]}}, den}))
                          : NUM_W'({{(NUM_W-DEN_W){1'b0}}, den});
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff[NUM_W-1:0], q_ff[NUM_W-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = anum; r_in = '0; d_in = aden;
         qneg_in = num[NUM_W-1] ^ den[DEN_W-1];
         rneg_in = num[NUM_W-1];
         cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[NUM_W-1:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
   end
   assign quot = qneg_ff ? $signed(-q_ff) : $signed(q_ff);
   assign rem  = rneg_ff ? $signed(-r_ff[NUM_W-1:0]) : $signed(r_ff[NUM_W-1:0]);
   // done is registered alongside the last iteration, so quot and rem are settled while it is high
   assign done = done_ff;
endmodule
`default_nettype wire

// File: rtl/voxel_grid_downsample_core.sv
// Voxel grid downsampler: bins Q16.16 points into voxels and drains centroids.
// Add: three divisions bin the point, then a probe of each entry up to the first key
//   match, then one update, after which the core is idle again.
// Drain: a search over every entry, then three divisions for the mean; on an empty
//   table the result is written without any division.
// Sync reset clears control, entries_used and overflow; entries at or above
// entries_used count as empty. Depends on vgd_pkg, vgd_req_if, vgd_rsp_if, vgd_div.
`default_nettype none
module voxel_grid_downsample_core #(
   parameter int unsigned MAX_VOXELS = 1024,
   parameter int unsigned COORD_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [vgd_pkg::SIZE_W-1:0]  csr_write_data,
   vgd_req_if.sink                          req,
   vgd_rsp_if.source                        rsp
);
   localparam int unsigned IDX_W = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
   localparam int unsigned USE_W = $clog2(MAX_VOXELS + 1);
   localparam int unsigned DW    = vgd_pkg::DATA_W;
   localparam int unsigned SW    = vgd_pkg::SUM_W;
   localparam int unsigned KW    = DW + 1;

   typedef struct packed {
      logic signed [DW-1:0] kx, ky, kz;
      logic [DW-1:0]        cnt;
      logic [SW-1:0]        sx, sy, sz;
      logic                 emitted;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_DIVW, S_SCAN, S_SCANW, S_UPD, S_DRN, S_DRNW, S_MEAN,
      S_MEANW, S_OUT
   } state_type;

   // Table memory; entries below used_ff are valid, the emitted flag lives in the entry
   entry_type           mem [MAX_VOXELS];

   state_type            state_ff;
   logic [vgd_pkg::SIZE_W-1:0] size_ff;
   logic [USE_W-1:0]     used_ff;
   logic                 ovf_ff;
   logic signed [DW-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [DW-1:0] key_ff [3];
   logic [1:0]           axis_ff;
   logic [USE_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     hit_ff;
   logic                 found_ff;
   logic [USE_W-1:0]     remain_ff;
   entry_type            rd_ff, best_ff;
   logic                 rsp_valid_ff;
   vgd_pkg::rsp_type     rsp_ff;
   logic signed [DW-1:0] mean_ff [3];

   // Sign-extend from COORD_BITS
   function automatic logic signed [DW-1:0] coord_of(input logic [DW-1:0] raw);
      coord_of = $signed(raw << (DW - COORD_BITS)) >>> (DW - COORD_BITS);
   endfunction

   logic signed [DW-1:0] cur_coord;
   always_comb begin
      unique case (axis_ff)
         2'd0:    cur_coord = cx_ff;
         2'd1:    cur_coord = cy_ff;
         default: cur_coord = cz_ff;
      endcase
   end

   // Shared divider: floor binning on add, mean on drain
   logic                 div_start, div_done;
   logic signed [SW-1:0] div_num, div_q, div_r;
   logic signed [KW-1:0] div_den;
   logic [SW-1:0]        best_sum;
   always_comb begin
      unique case (axis_ff)
         2'd0:    best_sum = best_ff.sx;
         2'd1:    best_sum = best_ff.sy;
         default: best_sum = best_ff.sz;
      endcase
   end
   assign div_start = (state_ff == S_DIV) || (state_ff == S_MEAN);
   assign div_num = (state_ff == S_MEAN) ? $signed(best_sum)
                                         : SW'($signed(cur_coord));
   assign div_den = (state_ff == S_MEAN) ? $signed({1'b0, best_ff.cnt})
                  : $signed({2'b0, (size_ff == '0) ? vgd_pkg::SIZE_W'(1) : size_ff});

   vgd_div #(.NUM_W(SW), .DEN_W(KW)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q), .rem(div_r)
   );

   logic signed [SW-1:0] floor_q;
   assign floor_q = (div_r != '0 && cur_coord < 0) ? div_q - 1'b1 : div_q;

   // Key compare of scanned entry against current best (signed, x then y then z)
   logic rd_less;
   always_comb begin
      if (rd_ff.kx != best_ff.kx)      rd_less = rd_ff.kx < best_ff.kx;
      else if (rd_ff.ky != best_ff.ky) rd_less = rd_ff.ky < best_ff.ky;
      else                             rd_less = rd_ff.kz < best_ff.kz;
   end

   logic [IDX_W-1:0] idx_lo, prev_lo;
   assign idx_lo  = idx_ff[IDX_W-1:0];
   assign prev_lo = IDX_W'(idx_ff - 1'b1);

   logic      wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[idx_lo];
   end

   // Write back: accumulate on add, mark the drained entry emitted on drain
   always_comb begin
      wr_en = 1'b0; wr_addr = hit_ff; wr_data = best_ff;
      if (state_ff == S_UPD) begin
         if (found_ff) begin
            wr_en = (best_ff.cnt != '1);
         end else begin
            wr_en = (used_ff < USE_W'(MAX_VOXELS));
            wr_addr = IDX_W'(used_ff);
            wr_data.kx = key_ff[0]; wr_data.ky = key_ff[1]; wr_data.kz = key_ff[2];
            wr_data.cnt = '0; wr_data.sx = '0; wr_data.sy = '0; wr_data.sz = '0;
            wr_data.emitted = 1'b0;
         end
         wr_data.cnt = wr_data.cnt + 1'b1;
         wr_data.sx  = wr_data.sx + SW'($signed(cx_ff));
         wr_data.sy  = wr_data.sy + SW'($signed(cy_ff));
         wr_data.sz  = wr_data.sz + SW'($signed(cz_ff));
      end else if (state_ff == S_OUT) begin
         wr_en = !rsp_valid_ff;
         wr_data.emitted = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; size_ff <= vgd_pkg::SIZE_RESET;
         used_ff <= '0; ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) size_ff <= csr_write_data;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               cx_ff <= coord_of(req.payload.point_x);
               cy_ff <= coord_of(req.payload.point_y);
               cz_ff <= coord_of(req.payload.point_z);
               axis_ff <= 2'd0; idx_ff <= '0; found_ff <= 1'b0; remain_ff <= '0;
               state_ff <= (req.payload.mode == vgd_pkg::MODE_DRAIN) ? S_DRN : S_DIV;
            end
            // Bin each axis through the divider
            S_DIV:  state_ff <= S_DIVW;
            S_DIVW: if (div_done) begin
               key_ff[axis_ff] <= DW'(floor_q);
               if (axis_ff == 2'd2) begin
                  axis_ff <= 2'd0; idx_ff <= '0; state_ff <= S_SCAN;
               end else begin
                  axis_ff <= axis_ff + 1'b1; state_ff <= S_DIV;
               end
            end
            // Probe valid entries in arrival order for a key match
            S_SCAN: begin
               if (idx_ff >= used_ff) state_ff <= S_UPD;
               else begin idx_ff <= idx_ff + 1'b1; state_ff <= S_SCANW; end
            end
            S_SCANW: begin
               if (rd_ff.kx == key_ff[0] && rd_ff.ky == key_ff[1] &&
                   rd_ff.kz == key_ff[2]) begin
                  // Hold the matching entry for the update
                  found_ff <= 1'b1; hit_ff <= prev_lo; best_ff <= rd_ff;
                  state_ff <= S_UPD;
               end else state_ff <= S_SCAN;
            end
            S_UPD: begin
               if (!found_ff) begin
                  if (used_ff < USE_W'(MAX_VOXELS)) used_ff <= used_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            // Search remaining entries for the smallest key
            S_DRN: begin
               if (idx_ff >= used_ff) begin
                  if (!found_ff) begin
                     // Hold until the result register is free
                     if (!rsp_valid_ff) begin
                        rsp_ff <= '{centroid_x: '0, centroid_y: '0, centroid_z: '0,
                                    last_voxel: 1'b0, table_empty: 1'b1,
                                    overflowed: ovf_ff};
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                  end else begin
                     axis_ff <= 2'd0; state_ff <= S_MEAN;
                  end
               end else begin idx_ff <= idx_ff + 1'b1; state_ff <= S_DRNW; end
            end
            S_DRNW: begin
               if (!rd_ff.emitted) begin
                  remain_ff <= remain_ff + 1'b1;
                  if (!found_ff || rd_less) begin
                     best_ff <= rd_ff; hit_ff <= prev_lo; found_ff <= 1'b1;
                  end
               end
               state_ff <= S_DRN;
            end
            S_MEAN:  state_ff <= S_MEANW;
            S_MEANW: if (div_done) begin
               mean_ff[axis_ff] <= DW'(div_q);
               if (axis_ff == 2'd2) state_ff <= S_OUT;
               else begin axis_ff <= axis_ff + 1'b1; state_ff <= S_MEAN; end
            end
            // Hold until the result register is free, then emit and mark the entry
            S_OUT: if (!rsp_valid_ff) begin
               rsp_ff <= '{centroid_x: mean_ff[0], centroid_y: mean_ff[1],
                           centroid_z: mean_ff[2],
                           last_voxel: (remain_ff == USE_W'(1)),
                           table_empty: 1'b0, overflowed: ovf_ff};
               rsp_valid_ff <= 1'b1;
               // Drop the whole table after the last voxel
               if (remain_ff == USE_W'(1)) begin
                  used_ff <= '0; ovf_ff <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USE_W'(MAX_VOXELS)) else $error("entries_used beyond table");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == S_IDLE) else $error("result before done");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("result changed while waiting");
endmodule
`default_nettype wire

// File: bench/vgd_checker.sv
// Checker for the voxel grid downsampler: watches both channels and the CSR port,
// keeps its own voxel table, predicts each centroid and compares it.
// Depends on vgd_pkg, vgd_req_if, vgd_rsp_if.
module vgd_checker #(
   parameter int unsigned MAX_VOXELS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [vgd_pkg::SIZE_W-1:0] csr_write_data,
   vgd_req_if.sink                    req_mon,
   vgd_rsp_if.sink                    rsp_mon,
   output int                         fail_count,
   output int                         centroids_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [vgd_pkg::SIZE_W-1:0] edge_len;
   logic               used_q   [MAX_VOXELS];
   logic               done_q   [MAX_VOXELS];
   logic signed [31:0] kx [MAX_VOXELS], ky [MAX_VOXELS], kz [MAX_VOXELS];
   logic [31:0]        cnt      [MAX_VOXELS];
   logic signed [63:0] sx [MAX_VOXELS], sy [MAX_VOXELS], sz [MAX_VOXELS];
   int                 fill;
   logic               ovf;
   vgd_pkg::rsp_type   centroid_q[$];

   function automatic logic signed [31:0] bin_of(logic signed [31:0] c);
      longint a, d, q;
      a = c;
      d = (edge_len == 0) ? 1 : longint'(edge_len);
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] mean_of(logic signed [63:0] s, logic [31:0] n);
      longint m;
      m = (n == 0) ? 0 : s / longint'({32'd0, n});
      return m[31:0];
   endfunction

   function automatic logic key_lt(int a, int b);
      if (kx[a] != kx[b]) return kx[a] < kx[b];
      if (ky[a] != ky[b]) return ky[a] < ky[b];
      return kz[a] < kz[b];
   endfunction

   task automatic clear_voxels();
      for (int i = 0; i < MAX_VOXELS; i++) begin
         used_q[i] = 0;
         done_q[i] = 0;
      end
      fill = 0;
      ovf  = 0;
   endtask

   task automatic add_point(vgd_pkg::req_type p);
      logic signed [31:0] bx, by, bz;
      int slot;
      bx = bin_of(p.point_x);
      by = bin_of(p.point_y);
      bz = bin_of(p.point_z);
      slot = -1;
      for (int i = 0; i < fill; i++)
         if (used_q[i] && kx[i] == bx && ky[i] == by && kz[i] == bz) begin
            slot = i;
            break;
         end
      if (slot < 0) begin
         if (fill >= MAX_VOXELS) begin
            ovf = 1;
            return;
         end
         slot = fill++;
         used_q[slot] = 1;
         done_q[slot] = 0;
         kx[slot] = bx; ky[slot] = by; kz[slot] = bz;
         cnt[slot] = 0; sx[slot] = 0; sy[slot] = 0; sz[slot] = 0;
      end
      if (cnt[slot] == 32'hFFFF_FFFF) return;
      cnt[slot]++;
      sx[slot] += p.point_x;
      sy[slot] += p.point_y;
      sz[slot] += p.point_z;
   endtask

   task automatic drain_next();
      vgd_pkg::rsp_type r;
      int best, left;
      best = -1;
      left = 0;
      for (int i = 0; i < fill; i++) begin
         if (!used_q[i] || done_q[i]) continue;
         left++;
         if (best < 0 || key_lt(i, best)) best = i;
      end
      r = '0;
      r.overflowed = ovf;
      if (best < 0) begin
         r.table_empty = 1;
      end else begin
         r.centroid_x = mean_of(sx[best], cnt[best]);
         r.centroid_y = mean_of(sy[best], cnt[best]);
         r.centroid_z = mean_of(sz[best], cnt[best]);
         r.last_voxel = (left == 1);
         done_q[best] = 1;
         if (left == 1) clear_voxels();
      end
      centroid_q.insert(centroid_q.size(), r);
   endtask

   always @(posedge clock) begin
      vgd_pkg::rsp_type exp_r;
      if (reset) begin
         edge_len = vgd_pkg::SIZE_RESET;
         clear_voxels();
         centroid_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) edge_len = csr_write_data;
         // check output first: a result can never stem from a request in the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (centroid_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected centroid %p", rsp_mon.payload);
            end else begin
               exp_r = centroid_q.pop_front();
               if (rsp_mon.payload !== exp_r) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("centroid mismatch: expected %p got %p", exp_r,
                              rsp_mon.payload);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.payload.mode == vgd_pkg::MODE_DRAIN) drain_next();
            else add_point(req_mon.payload);
         end
      end
      centroids_pending = centroid_q.size();
   end
endmodule

// File: bench/tb.sv
// Top of the voxel grid downsampler bench: clock, reset, CSR writes, request
// stimulus and result stalls; the verdict comes from vgd_checker.
// Depends on vgd_pkg, vgd_req_if, vgd_rsp_if, voxel_grid_downsample_core, vgd_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_GAP = 4000;     // idle cycles before a CSR write
   localparam int CYCLE_LIMIT = 12_000_000;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [vgd_pkg::SIZE_W-1:0] csr_write_data = '0;
   int fail_count, centroids_pending;
   int cycle_count = 0;
   int burst_left = 0;

   vgd_req_if req ();
   vgd_rsp_if rsp ();

   voxel_grid_downsample_core dut (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req(req.sink), .rsp(rsp.source)
   );

   vgd_checker chk (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_mon(req), .rsp_mon(rsp),
      .fail_count, .centroids_pending
   );

   always #5 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stall the result channel on its own pattern: quiet phases and choppy phases.
   int stall_mode = 0;
   initial rsp.ready = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp.ready <= 1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         default: rsp.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Hold a request until accepted; insert random gaps between bursts.
   task automatic send_request(vgd_pkg::req_type p);
      if (burst_left == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 5) == 0) burst_left = 0;
      end else begin
         burst_left--;
      end
      req.payload <= p;
      req.valid   <= 1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vgd_pkg::req_type p;
      p.mode = vgd_pkg::MODE_ADD;
      p.point_x = x; p.point_y = y; p.point_z = z;
      send_request(p);
   endtask

   task automatic pull_centroid();
      vgd_pkg::req_type p;
      p.mode = vgd_pkg::MODE_DRAIN;
      p.point_x = $urandom; p.point_y = $urandom; p.point_z = $urandom;
      send_request(p);
   endtask

   // Drop valid, wait for every result, then let the last add settle.
   task automatic settle();
      req.valid <= 0;
      while (centroids_pending != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic write_edge(logic [vgd_pkg::SIZE_W-1:0] v);
      settle();
      csr_write_data   <= v;
      csr_write_enable <= 1;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   // Coordinate clustered around a few centers so voxels gather several points.
   function automatic logic [31:0] near_coord(logic [31:0] c);
      int unsigned spread;
      spread = 1 << $urandom_range(4, 20);
      return c + $urandom_range(0, spread) - spread / 2;
   endfunction

   initial begin
      logic [31:0] cx, cy, cz;
      int n;
      req.valid = 0;
      req.payload = '0;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty drain, extremes, negative floor, same voxel accumulation.
      pull_centroid();
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      push_point(32'hFFFF_0001, 32'h0001_0000, 32'hFFFF_FFFF);
      push_point(32'hFFFF_8000, 32'h0001_8000, 32'hFFFF_0000);
      push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      pull_centroid();
      push_point(32'h0000_0001, 32'h0000_0002, 32'h0000_0003); // lands in an existing voxel
      push_point(32'h0005_0000, 32'hFFF0_0000, 32'h0002_0000); // new voxel mid drain
      repeat (6) pull_centroid();

      // Extreme voxel sizes; zero and full-width values.
      write_edge('0);
      push_point(32'h0000_0005, 32'hFFFF_FFFB, 32'h1234_5678);
      push_point(32'h0000_0005, 32'hFFFF_FFFB, 32'h1234_5678);
      pull_centroid();
      pull_centroid();
      write_edge({vgd_pkg::SIZE_W{1'b1}});
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0001);
      push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      repeat (4) pull_centroid();

      // Random phases with varying sizes; drains interleaved with adds.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph % 4)
            0: write_edge(31'd65536);
            1: write_edge(vgd_pkg::SIZE_W'($urandom_range(1, 16)));
            2: write_edge(vgd_pkg::SIZE_W'($urandom_range(1 << 16, 1 << 22)));
            default: write_edge(vgd_pkg::SIZE_W'($urandom));
         endcase
         n = $urandom_range(100, 120);
         cx = $urandom; cy = $urandom; cz = $urandom;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
               cx = $urandom; cy = $urandom; cz = $urandom;
            end
            if ($urandom_range(0, 9) == 0) push_point($urandom, $urandom, $urandom);
            else if ($urandom_range(0, 7) == 0) pull_centroid();
            else push_point(near_coord(cx), near_coord(cy), near_coord(cz));
         end
         if (ph == 3) settle(); // pause until every result is back
         for (int i = 0; i < 20; i++) pull_centroid();
      end

      settle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
